// ----- sv/circular_queue_unique_key_defines.svh -----
// ----------------------------------------------------------------------------
// Circular queue assertion macros
// Shared concurrent assertion forms; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_UNIQUE_KEY_DEFINES_SVH
`define CIRCULAR_QUEUE_UNIQUE_KEY_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CQUK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// next-cycle implication
`define CQUK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define CQUK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CQUK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/cquk_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular queue package
// Request and status codes, record layout and controller/datapath links.
// ----------------------------------------------------------------------------
package cquk_pkg;

    localparam int KEY_W = 16;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ENQ_UNIQUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENQ_PLAIN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEQ        = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] cook;
        logic [KEY_W-1:0] stay;
        logic [KEY_W-1:0] price;
    } rec_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic deq_read;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

// ----- sv/cquk_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular queue controller
// Sequences each request to commit, after a key scan (unique enqueue, query) or head read (dequeue).
// ----------------------------------------------------------------------------
module cquk_ctrl
    import cquk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] req_type,
    input  sts_t             sts,
    output cmd_t             cmd,
    output logic             busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DEQ  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (req_type)
                        REQ_ENQ_UNIQUE: state_next = S_SCAN;
                        REQ_QUERY:      state_next = S_SCAN;
                        REQ_DEQ:        state_next = S_DEQ;
                        REQ_ENQ_PLAIN:  state_next = S_FIN;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_DEQ:
            begin
                cmd.deq_read = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- sv/cquk_dp.sv -----
// ----------------------------------------------------------------------------
// Circular queue datapath
// Record memory, ring pointers, key scan and result registers.
// ----------------------------------------------------------------------------
`include "circular_queue_unique_key_defines.svh"

module cquk_dp
    import cquk_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [REQ_W-1:0] req_type,
    input  logic [KEY_W-1:0] item_key,
    input  logic [KEY_W-1:0] item_cook,
    input  logic [KEY_W-1:0] item_stay,
    input  logic [KEY_W-1:0] item_price,
    output logic             done,
    output logic [ST_W-1:0]  status,
    output logic             key_found,
    output logic [KEY_W-1:0] out_key,
    output logic [KEY_W-1:0] out_cook,
    output logic [KEY_W-1:0] out_stay,
    output logic [KEY_W-1:0] out_price,
    output logic [CNT_W-1:0] fill_count,
    output logic             is_empty
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_left_reg, scan_left_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             found_reg, found_next;
    logic             res_valid_reg;

    logic [REQ_W-1:0] req_reg;
    rec_t             in_rec_reg;

    logic [ST_W-1:0]  status_reg, status_next;
    logic             key_found_reg, key_found_next;
    rec_t             out_rec_reg, out_rec_next;
    logic [CNT_W-1:0] fill_count_reg;
    logic             is_empty_reg;

    logic             hit;
    logic             issue;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;

    // compare the entry read last cycle
    assign hit = cmp_valid_reg && (rd_data_reg.key == in_rec_reg.key);

    assign issue = cmd.scan && (scan_left_reg != '0) && !found_reg;
    assign rd_en   = issue || cmd.deq_read;
    assign rd_addr = cmd.deq_read ? head_reg : scan_ptr_reg;

    assign sts.scan_done = hit || found_reg || ((scan_left_reg == '0) && !cmp_valid_reg);

    // advance the key scan
    always_comb
    begin
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        if (cmd.load)
        begin
            scan_ptr_next  = head_reg;
            scan_left_next = count_reg;
            found_next     = 1'b0;
        end
        else if (cmd.scan)
        begin
            found_next = found_reg | hit;
            if (issue)
            begin
                cmp_valid_next = 1'b1;
                scan_ptr_next  = ptr_inc(scan_ptr_reg);
                scan_left_next = scan_left_reg - 1'b1;
            end
        end
    end

    // commit the request and form its result
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        status_next    = ST_DONE;
        key_found_next = 1'b0;
        out_rec_next   = '0;
        if (cmd.finish)
        begin
            unique case (req_reg)
                REQ_ENQ_UNIQUE, REQ_ENQ_PLAIN:
                begin
                    if ((req_reg == REQ_ENQ_UNIQUE) && found_reg)
                    begin
                        status_next    = ST_DUP;
                        key_found_next = 1'b1;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_DEQ:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_rec_next = rd_data_reg;
                        head_next    = ptr_inc(head_reg);
                        count_next   = count_reg - 1'b1;
                    end
                end
                REQ_QUERY:
                begin
                    key_found_next = found_reg;
                end
            endcase
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            scan_left_reg <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_left_reg <= scan_left_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            res_valid_reg <= cmd.finish;
        end
    end

    // latch the request and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            in_rec_reg <= '{key: item_key, cook: item_cook, stay: item_stay,
                            price: item_price};
        end
        if (cmd.finish)
        begin
            status_reg     <= status_next;
            key_found_reg  <= key_found_next;
            out_rec_reg    <= out_rec_next;
            fill_count_reg <= count_next;
            is_empty_reg   <= (count_next == '0);
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= in_rec_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done       = res_valid_reg;
    assign status     = status_reg;
    assign key_found  = key_found_reg;
    assign out_key    = out_rec_reg.key;
    assign out_cook   = out_rec_reg.cook;
    assign out_stay   = out_rec_reg.stay;
    assign out_price  = out_rec_reg.price;
    assign fill_count = fill_count_reg;
    assign is_empty   = is_empty_reg;

    `CQUK_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `CQUK_ASSERT_IMP(a_ring_consistent, clk, rst_n, 1'b1, (int'(head_reg) + int'(count_reg) == int'(tail_reg)) || (int'(head_reg) + int'(count_reg) == int'(tail_reg) + DEPTH))
    `CQUK_ASSERT_NXT(a_full_refused, clk, rst_n, cmd.finish && (req_reg == REQ_ENQ_PLAIN) && (count_reg == CNT_FULL), (status == ST_FULL) && $stable(count_reg))
    `CQUK_ASSERT_NXT(a_single_strobe, clk, rst_n, res_valid_reg, !res_valid_reg)

endmodule

// ----- sv/circular_queue_unique_key.sv -----
// ----------------------------------------------------------------------------
// Circular queue with duplicate key rejection
// Ring buffer of key/duration/price records with unique enqueue and lookup.
// ----------------------------------------------------------------------------
// Plain enqueue commits straight after the request is taken; dequeue reads the
//   head record before commit; unique enqueue or query scans the stored records
//   from head before commit, ending the scan early on a hit.
// The key scan reads one stored record per cycle from the single read port.
// busy drops as done rises, so a new request may start in the result cycle.
// Reset clears pointers, count and control; record storage is not cleared.
// Results are shown for one cycle on done and cannot be stalled.
module circular_queue_unique_key
    import cquk_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [REQ_W-1:0]             req_type,
    input  logic [KEY_W-1:0]             item_key,
    input  logic [KEY_W-1:0]             item_cook,
    input  logic [KEY_W-1:0]             item_stay,
    input  logic [KEY_W-1:0]             item_price,
    output logic                         done,
    output logic [ST_W-1:0]              status,
    output logic                         key_found,
    output logic [KEY_W-1:0]             out_key,
    output logic [KEY_W-1:0]             out_cook,
    output logic [KEY_W-1:0]             out_stay,
    output logic [KEY_W-1:0]             out_price,
    output logic [$clog2(DEPTH + 1)-1:0] fill_count,
    output logic                         is_empty
);

    cmd_t cmd;
    sts_t sts;

    cquk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    cquk_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .item_key   (item_key),
        .item_cook  (item_cook),
        .item_stay  (item_stay),
        .item_price (item_price),
        .done       (done),
        .status     (status),
        .key_found  (key_found),
        .out_key    (out_key),
        .out_cook   (out_cook),
        .out_stay   (out_stay),
        .out_price  (out_price),
        .fill_count (fill_count),
        .is_empty   (is_empty)
    );

endmodule
